// ----- src/gather_nd_address_generator_top_defines.svh -----
// assertion helpers for the gather-nd address generator
`ifndef GATHER_ND_ADDRESS_GENERATOR_TOP_DEFINES_SVH
`define GATHER_ND_ADDRESS_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GNAG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GNAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/gnag_pkg.sv -----
`timescale 1ns / 1ps
package gnag_pkg;

  localparam int MAX_RANK    = 8;
  localparam int MAX_SLICE   = 4;
  // batch_axes field is two bits wide
  localparam int BATCH_LANES = 3;
  localparam int NUM_LANES   = BATCH_LANES + MAX_SLICE;

  localparam int DIM_W     = 16;
  localparam int IDX_W     = DIM_W + 1;
  localparam int OPD_W     = IDX_W + 1;
  localparam int OFF_W     = 32;
  localparam int CNT_W     = 24;
  localparam int TPB_W     = CNT_W + 1;
  localparam int RANK_W    = 4;
  localparam int BA_W      = 2;
  localparam int SR_W      = 3;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int AXIS_W    = $clog2(MAX_RANK);

  localparam logic [CFG_W-1:0] DIMS_RESET = 64'h0001_0001_0001_0001;
  localparam logic [TPB_W-1:0] TPB_MAX    = TPB_W'(1) << CNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_DIMS_LOW    = 3'd0,
    REG_DATA_DIMS_HIGH   = 3'd1,
    REG_INDEX_BATCH_DIMS = 3'd2,
    REG_DATA_RANK        = 3'd3,
    REG_BATCH_AXES       = 3'd4,
    REG_SLICE_RANK       = 3'd5,
    REG_TUPLES_PER_BATCH = 3'd6
  } gnag_reg_e;

  typedef struct packed {
    logic                                busy;
    logic [BA_W-1:0]                     batch_axes;
    logic [SR_W-1:0]                     slice_rank;
    logic [TPB_W-1:0]                    tpb;
    logic [BATCH_LANES-1:0][DIM_W-1:0]   shape;
    logic [BATCH_LANES-1:0][OFF_W-1:0]   batch_stride;
    logic [MAX_SLICE-1:0][DIM_W-1:0]     lane_dim;
    logic [MAX_SLICE-1:0][OFF_W-1:0]     lane_stride;
    logic [OFF_W-1:0]                    slice_len;
  } gnag_cfg_t;

  typedef struct packed {
    logic [OFF_W-1:0] dst;
    logic [OFF_W-1:0] len;
    logic             lob;
    logic             loa;
  } gnag_ctl_t;

endpackage

// ----- src/gnag_if.sv -----
`timescale 1ns / 1ps
interface gnag_in_if;
  import gnag_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [IDX_W-1:0] index_0;
  logic signed [IDX_W-1:0] index_1;
  logic signed [IDX_W-1:0] index_2;
  logic signed [IDX_W-1:0] index_3;

  modport source (output valid, index_0, index_1, index_2, index_3, input ready);
  modport sink   (input valid, index_0, index_1, index_2, index_3, output ready);
endinterface

interface gnag_out_if;
  import gnag_pkg::*;

  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] src_element_offset;
  logic [OFF_W-1:0] dst_element_offset;
  logic [OFF_W-1:0] slice_length;
  logic             last_of_batch;
  logic             last_of_all;

  modport source (output valid, src_element_offset, dst_element_offset, slice_length,
                  last_of_batch, last_of_all, input ready);
  modport sink   (input valid, src_element_offset, dst_element_offset, slice_length,
                  last_of_batch, last_of_all, output ready);
endinterface

// ----- src/gnag_cfg.sv -----
`timescale 1ns / 1ps
module gnag_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gnag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gnag_pkg::CFG_W-1:0]       cfg_wdata,
  output gnag_pkg::gnag_cfg_t              cfg
);
  import gnag_pkg::*;

  logic [CFG_W-1:0]  dims_lo_r;
  logic [CFG_W-1:0]  dims_hi_r;
  logic [CFG_W-1:0]  ibd_r;
  logic [RANK_W-1:0] rank_r;
  logic [BA_W-1:0]   ba_r;
  logic [SR_W-1:0]   sr_r;
  logic [TPB_W-1:0]  tpb_r;

  logic [2*CFG_W/DIM_W-1:0][DIM_W-1:0] all_dims;
  logic [CFG_W/DIM_W-1:0][DIM_W-1:0]   ibd_dims;
  logic [MAX_RANK-1:0][DIM_W-1:0]      dim_eff;
  logic [RANK_W-1:0]                   rank_eff;
  logic [SR_W-1:0]                     sr_eff;
  logic [TPB_W-1:0]                    tpb_eff;
  logic [BATCH_LANES-1:0][DIM_W-1:0]   shape;

  logic                                busy_r;
  logic [AXIS_W-1:0]                   cnt_r;
  logic [OFF_W-1:0]                    prod_r;
  logic [OFF_W-1:0]                    prod_nxt;
  logic [OFF_W+DIM_W-1:0]              prod_full;
  logic [BATCH_LANES-1:0][OFF_W-1:0]   bstride_r;
  logic [MAX_SLICE-1:0][OFF_W-1:0]     lstride_r;
  logic [MAX_SLICE-1:0][DIM_W-1:0]     ldim_r;
  logic [OFF_W-1:0]                    len_r;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_lo_r <= DIMS_RESET;
      dims_hi_r <= DIMS_RESET;
      ibd_r     <= DIMS_RESET;
      rank_r    <= RANK_W'(1);
      ba_r      <= '0;
      sr_r      <= SR_W'(1);
      tpb_r     <= TPB_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DATA_DIMS_LOW:    dims_lo_r <= cfg_wdata;
        REG_DATA_DIMS_HIGH:   dims_hi_r <= cfg_wdata;
        REG_INDEX_BATCH_DIMS: ibd_r     <= cfg_wdata;
        REG_DATA_RANK:        rank_r    <= cfg_wdata[RANK_W-1:0];
        REG_BATCH_AXES:       ba_r      <= cfg_wdata[BA_W-1:0];
        REG_SLICE_RANK:       sr_r      <= cfg_wdata[SR_W-1:0];
        REG_TUPLES_PER_BATCH: tpb_r     <= cfg_wdata[TPB_W-1:0];
        default: ;
      endcase
    end
  end

  assign all_dims = {dims_hi_r, dims_lo_r};
  assign ibd_dims = ibd_r;

  // effective settings
  always_comb begin
    if (rank_r == '0) begin
      rank_eff = RANK_W'(1);
    end else if (rank_r > RANK_W'(MAX_RANK)) begin
      rank_eff = RANK_W'(MAX_RANK);
    end else begin
      rank_eff = rank_r;
    end
    if (sr_r == '0) begin
      sr_eff = SR_W'(1);
    end else if (sr_r > SR_W'(MAX_SLICE)) begin
      sr_eff = SR_W'(MAX_SLICE);
    end else begin
      sr_eff = sr_r;
    end
    if (tpb_r == '0) begin
      tpb_eff = TPB_W'(1);
    end else if (tpb_r > TPB_MAX) begin
      tpb_eff = TPB_MAX;
    end else begin
      tpb_eff = tpb_r;
    end
    for (int a = 0; a < MAX_RANK; a++) begin
      dim_eff[a] = (RANK_W'(a) < rank_eff) ? all_dims[a] : DIM_W'(1);
    end
    for (int i = 0; i < BATCH_LANES; i++) begin
      shape[i] = (dim_eff[i] > ibd_dims[i]) ? dim_eff[i] : ibd_dims[i];
      if (shape[i] == '0) begin
        shape[i] = DIM_W'(1);
      end
    end
  end

  // row-major strides, innermost axis first, one axis per cycle
  assign prod_full = prod_r * dim_eff[cnt_r];
  assign prod_nxt  = prod_full[OFF_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      busy_r <= 1'b1;
      cnt_r  <= AXIS_W'(MAX_RANK - 1);
      prod_r <= OFF_W'(1);
    end else if (busy_r) begin
      prod_r <= prod_nxt;
      cnt_r  <= cnt_r - AXIS_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      for (int i = 0; i < BATCH_LANES; i++) begin
        if (cnt_r == AXIS_W'(i)) begin
          bstride_r[i] <= (dim_eff[i] == DIM_W'(1)) ? '0 : prod_r;
        end
      end
      for (int i = 0; i < MAX_SLICE; i++) begin
        if (cnt_r == AXIS_W'(ba_r) + AXIS_W'(i)) begin
          lstride_r[i] <= prod_r;
          ldim_r[i]    <= dim_eff[cnt_r];
        end
      end
      if (cnt_r == AXIS_W'(ba_r) + AXIS_W'(sr_eff) - AXIS_W'(1)) begin
        len_r <= prod_r;
      end
    end
  end

  always_comb begin
    cfg.busy         = busy_r;
    cfg.batch_axes   = ba_r;
    cfg.slice_rank   = sr_eff;
    cfg.tpb          = tpb_eff;
    cfg.shape        = shape;
    cfg.batch_stride = bstride_r;
    cfg.lane_dim     = ldim_r;
    cfg.lane_stride  = lstride_r;
    cfg.slice_len    = len_r;
  end

endmodule

// ----- src/gnag_seq.sv -----
`timescale 1ns / 1ps
`include "gather_nd_address_generator_top_defines.svh"
module gnag_seq (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   en,
  input  logic                                                   accept,
  input  gnag_pkg::gnag_cfg_t                                    cfg,
  input  logic [gnag_pkg::MAX_SLICE-1:0][gnag_pkg::IDX_W-1:0]    idx_in,
  output logic                                                   v0,
  output logic [gnag_pkg::MAX_SLICE-1:0][gnag_pkg::IDX_W-1:0]    idx0,
  output logic [gnag_pkg::BATCH_LANES-1:0][gnag_pkg::DIM_W-1:0]  dig0,
  output gnag_pkg::gnag_ctl_t                                    ctl0
);
  import gnag_pkg::*;

  logic [CNT_W-1:0]                  cnt_r;
  logic [CNT_W-1:0]                  cnt_nxt;
  logic [BATCH_LANES-1:0][DIM_W-1:0] dig_r;
  logic [BATCH_LANES-1:0][DIM_W-1:0] dig_nxt;
  logic [OFF_W-1:0]                  off_r;
  logic [OFF_W-1:0]                  off_nxt;
  logic                              lob;
  logic                              loa;
  logic                              carry;

  logic                                v0_r;
  logic [MAX_SLICE-1:0][IDX_W-1:0]     idx0_r;
  logic [BATCH_LANES-1:0][DIM_W-1:0]   dig0_r;
  gnag_ctl_t                           ctl0_r;

  always_comb begin
    lob   = ({1'b0, cnt_r} + TPB_W'(1)) >= cfg.tpb;
    loa   = lob;
    carry = 1'b1;
    dig_nxt = dig_r;
    for (int k = BATCH_LANES - 1; k >= 0; k--) begin
      if (k < int'(cfg.batch_axes)) begin
        if (({1'b0, dig_r[k]} + (DIM_W+1)'(1)) < {1'b0, cfg.shape[k]}) begin
          loa = 1'b0;
          if (carry) begin
            dig_nxt[k] = dig_r[k] + DIM_W'(1);
            carry      = 1'b0;
          end
        end else if (carry) begin
          dig_nxt[k] = '0;
        end
      end
    end
    if (!lob) begin
      dig_nxt = dig_r;
    end
    cnt_nxt = lob ? '0 : cnt_r + CNT_W'(1);
    off_nxt = off_r + cfg.slice_len;
    if (loa) begin
      dig_nxt = '0;
      cnt_nxt = '0;
      off_nxt = '0;
    end
  end

  // batch counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      dig_r <= '0;
      off_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      dig_r <= dig_nxt;
      off_r <= off_nxt;
    end
  end

  // first pipeline stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx0_r     <= idx_in;
      dig0_r     <= dig_r;
      ctl0_r.dst <= off_r;
      ctl0_r.len <= cfg.slice_len;
      ctl0_r.lob <= lob;
      ctl0_r.loa <= loa;
    end
  end

  assign v0   = v0_r;
  assign idx0 = idx0_r;
  assign dig0 = dig0_r;
  assign ctl0 = ctl0_r;

  `GNAG_ASSERT_NEXT(a_loa_restart, accept && loa, (cnt_r == '0) && (off_r == '0) && (dig_r == '0), "end of output did not restart the counters")
  `GNAG_ASSERT_NEXT(a_cnt_step, accept && !lob, cnt_r == $past(cnt_r) + CNT_W'(1), "tuple counter did not advance")

endmodule

// ----- src/gnag_lane.sv -----
`timescale 1ns / 1ps
module gnag_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          active,
  input  logic [gnag_pkg::IDX_W-1:0]    idx,
  input  logic [gnag_pkg::DIM_W-1:0]    dim,
  input  logic [gnag_pkg::OFF_W-1:0]    stride,
  output logic [gnag_pkg::OFF_W-1:0]    prod
);
  import gnag_pkg::*;

  logic signed [OPD_W-1:0]       opd;
  logic signed [OPD_W+OFF_W:0]   full;
  logic [OFF_W-1:0]              prod_r;

  // negative index counts from the end of its axis
  always_comb begin
    opd = $signed({idx[IDX_W-1], idx});
    if (idx[IDX_W-1]) begin
      opd = opd + $signed({2'b00, dim});
    end
    full = opd * $signed({1'b0, stride});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= active ? full[OFF_W-1:0] : '0;
    end
  end

  assign prod = prod_r;

endmodule

// ----- src/gnag_merge.sv -----
`timescale 1ns / 1ps
module gnag_merge (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 en,
  input  logic                                                 v0,
  input  gnag_pkg::gnag_ctl_t                                  ctl0,
  input  logic [gnag_pkg::NUM_LANES-1:0][gnag_pkg::OFF_W-1:0]  prod,
  output logic                                                 out_valid,
  output logic [gnag_pkg::OFF_W-1:0]                           src,
  output gnag_pkg::gnag_ctl_t                                  ctl_out
);
  import gnag_pkg::*;

  localparam int L1 = (NUM_LANES + 1) / 2;
  localparam int L2 = (L1 + 1) / 2;

  logic [2*L1-1:0][OFF_W-1:0] p_pad;
  logic [2*L2-1:0][OFF_W-1:0] s1_pad;
  logic [L1-1:0][OFF_W-1:0]   s1_r;
  logic [L2-1:0][OFF_W-1:0]   s2_r;
  logic [OFF_W-1:0]           total;
  logic [OFF_W-1:0]           src_r;

  logic      v1_r, v2_r, v3_r, vo_r;
  gnag_ctl_t ctl1_r, ctl2_r, ctl3_r, ctlo_r;

  assign p_pad  = (2*L1*OFF_W)'(prod);
  assign s1_pad = (2*L2*OFF_W)'(s1_r);

  always_comb begin
    total = '0;
    for (int k = 0; k < L2; k++) begin
      total = total + s2_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  // pairwise adder tree, one level per stage
  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r <= ctl0;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctlo_r <= ctl3_r;
      for (int k = 0; k < L1; k++) begin
        s1_r[k] <= p_pad[2*k] + p_pad[2*k+1];
      end
      for (int k = 0; k < L2; k++) begin
        s2_r[k] <= s1_pad[2*k] + s1_pad[2*k+1];
      end
      src_r <= total;
    end
  end

  assign out_valid = vo_r;
  assign src       = src_r;
  assign ctl_out   = ctlo_r;

endmodule

// ----- src/gather_nd_address_generator_top.sv -----
// gather-nd address generator
// in_ch carries one index tuple per item (index_0..index_3, two's complement), in
// output order; components past slice_rank are ignored. out_ch returns one item per
// input item: source element offset, destination element offset, slice length and
// the end-of-batch / end-of-output flags. cfg_we/cfg_index/cfg_wdata write the
// configuration registers; the user must write only while no item is in flight,
// the block does not enforce this. the result passes through the counter stage,
// the lane multiply and three adder tree levels before out_ch.valid rises.
// throughput: one item per cycle from the pipelined lanes and tree, unless stalled.
// reset: registers go to their defaults, counters clear, and the stride sequencer
// walks the 8 data axes, one multiply per cycle, holding in_ch.ready low until the
// walk ends. every configuration write restarts the same walk.
// stall: while out_ch.valid is high and out_ch.ready is low the whole pipeline holds
// and in_ch.ready drops in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "gather_nd_address_generator_top_defines.svh"
module gather_nd_address_generator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  gnag_in_if.sink                         in_ch,
  gnag_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [gnag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gnag_pkg::CFG_W-1:0]      cfg_wdata
);
  import gnag_pkg::*;

  gnag_cfg_t                         cfg_s;
  gnag_ctl_t                         ctl0;
  gnag_ctl_t                         ctl_out;
  logic                              en;
  logic                              accept;
  logic                              v0;
  logic                              out_valid;
  logic [OFF_W-1:0]                  src;
  logic [MAX_SLICE-1:0][IDX_W-1:0]   idx_in;
  logic [MAX_SLICE-1:0][IDX_W-1:0]   idx0;
  logic [BATCH_LANES-1:0][DIM_W-1:0] dig0;
  logic [NUM_LANES-1:0][OFF_W-1:0]   prod;

  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en && !cfg_s.busy;
  assign accept      = in_ch.valid && in_ch.ready;

  assign idx_in[0] = in_ch.index_0;
  assign idx_in[1] = in_ch.index_1;
  assign idx_in[2] = in_ch.index_2;
  assign idx_in[3] = in_ch.index_3;

  gnag_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg_s)
  );

  gnag_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .accept (accept),
    .cfg    (cfg_s),
    .idx_in (idx_in),
    .v0     (v0),
    .idx0   (idx0),
    .dig0   (dig0),
    .ctl0   (ctl0)
  );

  // batch digit lanes
  for (genvar i = 0; i < BATCH_LANES; i++) begin : g_batch
    gnag_lane u_lane (
      .clk    (clk),
      .en     (en),
      .active (BA_W'(i) < cfg_s.batch_axes),
      .idx    ({1'b0, dig0[i]}),
      .dim    ('0),
      .stride (cfg_s.batch_stride[i]),
      .prod   (prod[i])
    );
  end

  // index component lanes
  for (genvar i = 0; i < MAX_SLICE; i++) begin : g_index
    gnag_lane u_lane (
      .clk    (clk),
      .en     (en),
      .active (SR_W'(i) < cfg_s.slice_rank),
      .idx    (idx0[i]),
      .dim    (cfg_s.lane_dim[i]),
      .stride (cfg_s.lane_stride[i]),
      .prod   (prod[BATCH_LANES+i])
    );
  end

  gnag_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .v0        (v0),
    .ctl0      (ctl0),
    .prod      (prod),
    .out_valid (out_valid),
    .src       (src),
    .ctl_out   (ctl_out)
  );

  assign out_ch.valid              = out_valid;
  assign out_ch.src_element_offset = src;
  assign out_ch.dst_element_offset = ctl_out.dst;
  assign out_ch.slice_length       = ctl_out.len;
  assign out_ch.last_of_batch      = ctl_out.lob;
  assign out_ch.last_of_all        = ctl_out.loa;

  `GNAG_ASSERT_IMPL(a_loa_has_lob, out_ch.valid && out_ch.last_of_all, out_ch.last_of_batch, "end of output without end of batch")
  `GNAG_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, !in_ch.ready, "input taken during stride setup")

endmodule

// ----- tb/sv/gather_nd_address_generator_top_tb.sv -----
`timescale 1ns / 1ps
module gather_nd_address_generator_top_tb;
  import gnag_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [OFF_W-1:0] src;
    logic [OFF_W-1:0] dst;
    logic [OFF_W-1:0] len;
    logic             lob;
    logic             loa;
  } gather_addr_t;

  typedef logic [3:0][IDX_W-1:0] index_tuple_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_TUPLE, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    gnag_reg_e    target;
    logic [63:0]  value;
    index_tuple_t idx;
    gather_addr_t typed;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  gnag_in_if  in_if ();
  gnag_out_if out_if ();

  gather_nd_address_generator_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register shadow
  logic [63:0] dims_lo_q, dims_hi_q, ibd_q;
  logic [RANK_W-1:0] rank_q;
  logic [BA_W-1:0] batch_axes_q;
  logic [SR_W-1:0] slice_rank_q;
  logic [TPB_W-1:0] tpb_q;

  // counter state
  logic [CNT_W-1:0] tuple_pos;
  int unsigned batch_digit [4];
  logic [OFF_W-1:0] out_base;
  logic [OFF_W-1:0] axis_stride [MAX_RANK];

  gather_addr_t pending_addrs [$];
  directed_row_t directed_rows [$];
  int mismatches = 0;

  bit steady;
  bit hold_off_req;
  bit hold_done = 1'b0;
  int hold_left = 0;

  function automatic logic [OFF_W-1:0] axis_size(input int a);
    int r;
    r = rank_q;
    if (r < 1) r = 1;
    if (r > MAX_RANK) r = MAX_RANK;
    if (a >= r) return 1;
    if (a < 4) return OFF_W'(dims_lo_q[16*a +: 16]);
    return OFF_W'(dims_hi_q[16*(a-4) +: 16]);
  endfunction

  function automatic void refresh_strides();
    logic [OFF_W-1:0] s;
    s = 1;
    for (int a = MAX_RANK - 1; a >= 0; a--) begin
      axis_stride[a] = s;
      s = s * axis_size(a);
    end
  endfunction

  function automatic logic [OFF_W-1:0] batch_shape(input int i);
    logic [OFF_W-1:0] d, x, m;
    d = axis_size(i);
    x = OFF_W'(ibd_q[16*i +: 16]);
    m = (d > x) ? d : x;
    return (m == 0) ? 1 : m;
  endfunction

  function automatic void load_reg(input gnag_reg_e r, input logic [63:0] v);
    case (r)
      REG_DATA_DIMS_LOW:    dims_lo_q = v;
      REG_DATA_DIMS_HIGH:   dims_hi_q = v;
      REG_INDEX_BATCH_DIMS: ibd_q = v;
      REG_DATA_RANK:        rank_q = v[RANK_W-1:0];
      REG_BATCH_AXES:       batch_axes_q = v[BA_W-1:0];
      REG_SLICE_RANK:       slice_rank_q = v[SR_W-1:0];
      REG_TUPLES_PER_BATCH: tpb_q = v[TPB_W-1:0];
      default: ;
    endcase
    refresh_strides();
  endfunction

  function automatic void reset_shadow();
    dims_lo_q = DIMS_RESET;
    dims_hi_q = DIMS_RESET;
    ibd_q = DIMS_RESET;
    rank_q = 1;
    batch_axes_q = 0;
    slice_rank_q = 1;
    tpb_q = 1;
    tuple_pos = '0;
    for (int i = 0; i < 4; i++) batch_digit[i] = 0;
    out_base = '0;
    refresh_strides();
  endfunction

  function automatic gather_addr_t next_gather_addr(input index_tuple_t idx);
    int ba, sr, a;
    logic [OFF_W-1:0] src, len, tpb, v, st;
    bit lob, loa, carry;
    gather_addr_t r;
    ba = batch_axes_q;
    sr = slice_rank_q;
    if (sr < 1) sr = 1;
    if (sr > MAX_SLICE) sr = MAX_SLICE;
    if (sr > 4) sr = 4;
    tpb = OFF_W'(tpb_q);
    if (tpb < 1) tpb = 1;
    if (tpb > (1 << CNT_W)) tpb = 1 << CNT_W;

    src = '0;
    for (int i = 0; i < ba; i++) begin
      st = (axis_size(i) == 1) ? '0 : axis_stride[i];
      src = src + OFF_W'(batch_digit[i]) * st;
    end
    for (int i = 0; i < sr; i++) begin
      a = ba + i;
      if (a < MAX_RANK) begin
        v = {{(OFF_W-IDX_W){idx[i][IDX_W-1]}}, idx[i]};
        if (idx[i][IDX_W-1]) v = v + axis_size(a);
        src = src + v * axis_stride[a];
      end
    end
    len = 1;
    for (a = ba + sr; a < MAX_RANK; a++) len = len * axis_size(a);

    lob = ({8'b0, tuple_pos} + 32'd1) >= tpb;
    loa = lob;
    for (int i = 0; i < ba; i++)
      if (batch_digit[i] + 1 < batch_shape(i)) loa = 1'b0;

    r.src = src;
    r.dst = out_base;
    r.len = len;
    r.lob = lob;
    r.loa = loa;

    out_base = out_base + len;
    if (lob) begin
      tuple_pos = '0;
      carry = 1'b1;
      for (int k = ba - 1; k >= 0; k--) begin
        if (carry) begin
          if (batch_digit[k] + 1 >= batch_shape(k)) begin
            batch_digit[k] = 0;
          end else begin
            batch_digit[k]++;
            carry = 1'b0;
          end
        end
      end
    end else begin
      tuple_pos = tuple_pos + 1'b1;
    end
    if (loa) begin
      for (int i = 0; i < 4; i++) batch_digit[i] = 0;
      out_base = '0;
      tuple_pos = '0;
    end
    return r;
  endfunction

  function automatic void add_write(input gnag_reg_e r, input logic [63:0] v);
    directed_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.target = r;
    row.value = v;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_tuple(input int i0, input int i1, input int i2, input int i3);
    directed_row_t row;
    row = '0;
    row.kind = ROW_TUPLE;
    row.idx = {IDX_W'(i3), IDX_W'(i2), IDX_W'(i1), IDX_W'(i0)};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(input int i0, input int i1, input int i2, input int i3,
                                    input logic [31:0] src, input logic [31:0] dst,
                                    input logic [31:0] len, input bit lob, input bit loa);
    directed_row_t row;
    row = '0;
    row.kind = ROW_TYPED;
    row.idx = {IDX_W'(i3), IDX_W'(i2), IDX_W'(i1), IDX_W'(i0)};
    row.typed = '{src: src, dst: dst, len: len, lob: lob, loa: loa};
    directed_rows.push_back(row);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input int a);
    int d, x;
    d = int'(axis_size(a));
    if (d != 0 && $urandom_range(0, 99) < 80)
      x = int'($urandom_range(0, 2 * d - 1)) - d;
    else
      x = int'($urandom_range(0, 131070)) - 65535;
    return IDX_W'(x);
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [15:0] pick_batch_dim();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom);
      2, 3: return 16'd1;
      default: return 16'($urandom_range(1, 3));
    endcase
  endfunction

  task automatic write_reg(input gnag_reg_e r, input logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    load_reg(r, v);
  endtask

  task automatic drain_results(input int extra);
    in_if.valid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic send_tuple(input index_tuple_t idx);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.index_0 <= idx[0];
    in_if.index_1 <= idx[1];
    in_if.index_2 <= idx[2];
    in_if.index_3 <= idx[3];
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic random_config();
    logic [63:0] lo, hi, ib;
    logic [63:0] rank, ba, sr, tpb;
    for (int i = 0; i < 4; i++) begin
      lo[16*i +: 16] = pick_dim();
      hi[16*i +: 16] = pick_dim();
      ib[16*i +: 16] = pick_batch_dim();
    end
    case ($urandom_range(0, 9))
      0: rank = 0;
      1: rank = $urandom_range(9, 15);
      default: rank = $urandom_range(1, 8);
    endcase
    ba = $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0: sr = 0;
      1: sr = $urandom_range(5, 7);
      default: sr = $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 9))
      0: tpb = 0;
      1: tpb = $urandom_range(1 << 24, (1 << 25) - 1);
      2: tpb = 1 << 24;
      default: tpb = $urandom_range(1, 5);
    endcase
    write_reg(REG_DATA_DIMS_LOW, lo);
    write_reg(REG_DATA_DIMS_HIGH, hi);
    write_reg(REG_INDEX_BATCH_DIMS, ib);
    write_reg(REG_DATA_RANK, rank);
    write_reg(REG_BATCH_AXES, ba);
    write_reg(REG_SLICE_RANK, sr);
    write_reg(REG_TUPLES_PER_BATCH, tpb);
  endtask

  // result side: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_off_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 150;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(0, 99) >= 28);
    end
  end

  always @(posedge clk) begin
    gather_addr_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_addrs.size() == 0) begin
        $error("result item with nothing pending");
        mismatches++;
      end else begin
        want = pending_addrs.pop_front();
        if (out_if.src_element_offset !== want.src) begin
          $error("src_element_offset expected %h got %h", want.src, out_if.src_element_offset);
          mismatches++;
        end
        if (out_if.dst_element_offset !== want.dst) begin
          $error("dst_element_offset expected %h got %h", want.dst, out_if.dst_element_offset);
          mismatches++;
        end
        if (out_if.slice_length !== want.len) begin
          $error("slice_length expected %h got %h", want.len, out_if.slice_length);
          mismatches++;
        end
        if (out_if.last_of_batch !== want.lob) begin
          $error("last_of_batch expected %b got %b", want.lob, out_if.last_of_batch);
          mismatches++;
        end
        if (out_if.last_of_all !== want.loa) begin
          $error("last_of_all expected %b got %b", want.loa, out_if.last_of_all);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int n;
    int phase_no;
    int items_sent;
    index_tuple_t idx;
    gather_addr_t predicted;
    directed_row_t row;

    in_if.valid = 1'b0;
    in_if.index_0 = '0;
    in_if.index_1 = '0;
    in_if.index_2 = '0;
    in_if.index_3 = '0;
    cfg_we = 1'b0;
    cfg_index = REG_DATA_DIMS_LOW;
    cfg_wdata = '0;
    steady = 1'b0;
    hold_off_req = 1'b0;
    reset_shadow();

    // defaults: one axis of size 1, every tuple ends the output
    add_typed(0, 0, 0, 0, 32'h0, 32'h0, 32'h1, 1'b1, 1'b1);
    add_typed(65535, -65535, 65535, -65535, 32'h0000_FFFF, 32'h0, 32'h1, 1'b1, 1'b1);
    add_typed(-65535, 65535, -1, 0, 32'hFFFF_0002, 32'h0, 32'h1, 1'b1, 1'b1);
    add_typed(-1, 1, -1, 1, 32'h0, 32'h0, 32'h1, 1'b1, 1'b1);
    // rank zero behaves as rank one
    add_write(REG_DATA_RANK, 64'd0);
    add_typed(5, -7, 3, -2, 32'h5, 32'h0, 32'h1, 1'b1, 1'b1);
    // one batch axis, two tuples per batch
    add_write(REG_DATA_DIMS_LOW, 64'h0000_0005_0003_0004);
    add_write(REG_INDEX_BATCH_DIMS, 64'h0001_0001_0001_0002);
    add_write(REG_DATA_RANK, 64'd3);
    add_write(REG_BATCH_AXES, 64'd1);
    add_write(REG_SLICE_RANK, 64'd1);
    add_write(REG_TUPLES_PER_BATCH, 64'd2);
    add_tuple(0, 0, 0, 0);
    add_tuple(2, 0, 0, 0);
    add_tuple(-1, 0, 0, 0);
    add_tuple(-3, 0, 0, 0);
    add_tuple(1, 0, 0, 0);
    // shrink limits under a running count
    add_write(REG_DATA_DIMS_LOW, 64'h0000_0005_0003_0002);
    add_write(REG_TUPLES_PER_BATCH, 64'd1);
    add_tuple(-2, 0, 0, 0);
    // zero sized axis
    add_write(REG_DATA_DIMS_LOW, 64'h0000_0000_0003_0004);
    add_tuple(1, 0, 0, 0);
    add_tuple(-1, 0, 0, 0);
    // broadcast data batch axis
    add_write(REG_DATA_DIMS_LOW, 64'h0000_0005_0003_0001);
    add_write(REG_INDEX_BATCH_DIMS, 64'h0001_0001_0001_0003);
    add_tuple(2, 0, 0, 0);
    add_tuple(-3, 0, 0, 0);
    add_tuple(0, 0, 0, 0);
    // everything at its extreme
    add_write(REG_DATA_DIMS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    add_write(REG_DATA_DIMS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_write(REG_INDEX_BATCH_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
    add_write(REG_DATA_RANK, 64'd15);
    add_write(REG_BATCH_AXES, 64'd3);
    add_write(REG_SLICE_RANK, 64'd7);
    add_write(REG_TUPLES_PER_BATCH, 64'd0);
    add_tuple(65535, -65535, 65535, -65535);
    add_tuple(-65535, 65535, -65535, 65535);
    add_write(REG_SLICE_RANK, 64'd0);
    add_write(REG_TUPLES_PER_BATCH, 64'h1FF_FFFF);
    add_tuple(-1, -1, -1, -1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain_results(DRAIN_CYCLES);
        write_reg(row.target, row.value);
      end else begin
        send_tuple(row.idx);
        predicted = next_gather_addr(row.idx);
        pending_addrs.push_back((row.kind == ROW_TYPED) ? row.typed : predicted);
      end
    end

    items_sent = 0;
    phase_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain_results(DRAIN_CYCLES);
      random_config();
      steady <= (phase_no == 6 || phase_no == 7);
      n = $urandom_range(15, 50);
      if (phase_no == 3) begin
        hold_off_req <= 1'b1;
        n = 60;
      end
      for (int j = 0; j < n; j++) begin
        if (phase_no == 5 && j == 20) drain_results(0);
        for (int c = 0; c < 4; c++) idx[c] = pick_index(batch_axes_q + c);
        send_tuple(idx);
        pending_addrs.push_back(next_gather_addr(idx));
        items_sent++;
      end
      phase_no++;
    end

    drain_results(10);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- gather_nd_address_generator_top.f -----
+incdir+src
src/gnag_pkg.sv
src/gnag_if.sv
src/gnag_cfg.sv
src/gnag_seq.sv
src/gnag_lane.sv
src/gnag_merge.sv
src/gather_nd_address_generator_top.sv
tb/sv/gather_nd_address_generator_top_tb.sv
